/* sv/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masked
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication, reset masked
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

/* sv/otb_pkg.sv */
// types and constants of the otsu threshold binarizer
`default_nettype none
package otb_pkg;

  localparam logic CMD_ACC = 1'b0;
  localparam logic CMD_BIN = 1'b1;

  localparam logic KIND_THRESH = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam logic [7:0] PIX_WHITE = 8'd255;
  localparam logic [7:0] PIX_BLACK = 8'd0;

  typedef enum logic [2:0] {
    MOP_X,
    MOP_Y,
    MOP_D,
    MOP_P,
    MOP_L,
    MOP_R
  } mop_t;

  typedef struct packed {
    logic accept;
    logic acc_wr;
    logic srch_init;
    logic lvl_rd;
    logic bin_add;
    logic mul_start;
    logic mul_take;
    mop_t mop;
    logic best_upd;
    logic lvl_inc;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic n1_zero;
    logic n1_ge;
    logic lvl_last;
    logic mul_done;
    logic lhs_gt;
  } dp_status_t;

endpackage
`default_nettype wire

/* sv/otb_mul.sv */
// shift-add multiplier, one multiplier bit per cycle
`default_nettype none
module otb_mul #(
  parameter int AW = 8,
  parameter int BW = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [AW-1:0]      a,
  input  wire logic [BW-1:0]      b,
  output logic                    done,
  output logic [AW+BW-1:0]        prod
);

  localparam int PW = AW + BW;

  logic          busy;
  logic [PW-1:0] acc;
  logic [PW-1:0] aa;
  logic [BW-1:0] bb;

  assign done = busy && (bb == '0);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      aa  <= PW'(a);
      bb  <= b;
    end else if (busy && (bb != '0)) begin
      if (bb[0]) begin
        acc <= acc + aa;
      end
      aa <= aa << 1;
      bb <= bb >> 1;
    end
  end

endmodule
`default_nettype wire

/* sv/otb_datapath.sv */
// histogram memory, search registers and output register
`default_nettype none
module otb_datapath #(
  parameter int MAX_PIXELS  = 1048576,
  parameter int GRAY_LEVELS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire otb_pkg::ctrl_cmd_t ctl,
  output otb_pkg::dp_status_t     st,
  input  wire logic               cmd,
  input  wire logic [7:0]         pixel,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    result_kind,
  output logic [7:0]              value
);

  localparam int LW  = $clog2(GRAY_LEVELS);
  localparam int CW  = $clog2(MAX_PIXELS + 1);
  localparam int SW  = CW + 8;
  localparam int XW  = SW + CW;
  localparam int QW  = 2 * XW;
  localparam int PW  = 2 * CW;
  localparam int CPW = QW + PW;
  localparam int MW  = QW + XW;
  localparam logic [8:0]    LVL_MAX = 9'(GRAY_LEVELS - 1);
  localparam logic [LW-1:0] IDX_LAST = LW'(GRAY_LEVELS - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PIXELS);

  logic [CW-1:0] mem [GRAY_LEVELS];
  logic [GRAY_LEVELS-1:0] vld;
  logic [CW-1:0] rdata;
  logic          vq;
  logic [LW-1:0] raddr;

  logic [7:0]    lvl_in;
  logic [LW-1:0] idx_q;
  logic [7:0]    lvl_q;
  logic          take_q;

  logic [CW-1:0] count;
  logic [SW-1:0] sum;
  logic [7:0]    cur_thr;

  logic [LW-1:0]  lvl;
  logic [CW-1:0]  n1;
  logic [SW-1:0]  s1;
  logic [XW-1:0]  x;
  logic [XW-1:0]  y;
  logic [QW-1:0]  q;
  logic [PW-1:0]  p;
  logic [CPW-1:0] lhs;
  logic [CPW-1:0] rhs;
  logic [QW-1:0]  best_q;
  logic [PW-1:0]  best_p;
  logic [7:0]     thr;

  logic [CW-1:0] cnt;
  logic [XW-1:0] d;
  logic [CW-1:0] n2;
  logic [QW-1:0] ma;
  logic [XW-1:0] mb;
  logic          mdone;
  logic [MW-1:0] prod;

  assign lvl_in = ({1'b0, pixel} > LVL_MAX) ? LVL_MAX[7:0] : pixel;
  assign raddr  = ctl.lvl_rd ? lvl : lvl_in[LW-1:0];
  assign cnt    = vq ? rdata : '0;
  assign d      = (x > y) ? (x - y) : (y - x);
  assign n2     = count - n1;

  always_ff @(posedge clk) begin
    if (ctl.acc_wr && take_q) begin
      mem[idx_q] <= cnt + CW'(1);
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.finish) begin
      vld <= '0;
    end else if (ctl.acc_wr && take_q) begin
      vld[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vq <= vld[raddr];
    if (ctl.accept) begin
      idx_q  <= lvl_in[LW-1:0];
      lvl_q  <= lvl_in;
      take_q <= count < CNT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sum     <= '0;
      cur_thr <= '0;
    end else if (ctl.finish) begin
      count   <= '0;
      sum     <= '0;
      cur_thr <= thr;
    end else if (ctl.acc_wr && take_q) begin
      count <= count + CW'(1);
      sum   <= sum + SW'(lvl_q);
    end
  end

  always_comb begin
    unique case (ctl.mop)
      otb_pkg::MOP_X: begin ma = QW'(s1);     mb = XW'(count);  end
      otb_pkg::MOP_Y: begin ma = QW'(sum);    mb = XW'(n1);     end
      otb_pkg::MOP_D: begin ma = QW'(d);      mb = d;           end
      otb_pkg::MOP_P: begin ma = QW'(n1);     mb = XW'(n2);     end
      otb_pkg::MOP_L: begin ma = q;           mb = XW'(best_p); end
      otb_pkg::MOP_R: begin ma = best_q;      mb = XW'(p);      end
      default:        begin ma = '0;          mb = '0;          end
    endcase
  end

  otb_mul #(.AW(QW), .BW(XW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.mul_start),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (ctl.srch_init) begin
      lvl    <= '0;
      n1     <= '0;
      s1     <= '0;
      best_q <= '0;
      best_p <= PW'(1);
      thr    <= '0;
    end else begin
      if (ctl.bin_add) begin
        n1 <= n1 + cnt;
        s1 <= s1 + SW'(lvl * cnt);
      end
      if (ctl.lvl_inc) begin
        lvl <= lvl + LW'(1);
      end
      if (ctl.best_upd) begin
        best_q <= q;
        best_p <= p;
        thr    <= 8'(lvl);
      end
    end
    if (ctl.mul_take) begin
      unique case (ctl.mop)
        otb_pkg::MOP_X: x   <= XW'(prod);
        otb_pkg::MOP_Y: y   <= XW'(prod);
        otb_pkg::MOP_D: q   <= QW'(prod);
        otb_pkg::MOP_P: p   <= PW'(prod);
        otb_pkg::MOP_L: lhs <= CPW'(prod);
        otb_pkg::MOP_R: rhs <= CPW'(prod);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctl.accept && (cmd == otb_pkg::CMD_BIN)) || ctl.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      result_kind <= otb_pkg::KIND_THRESH;
      value       <= thr;
    end else if (ctl.accept && (cmd == otb_pkg::CMD_BIN)) begin
      result_kind <= otb_pkg::KIND_PIXEL;
      value       <= (pixel > cur_thr) ? otb_pkg::PIX_WHITE : otb_pkg::PIX_BLACK;
    end
  end

  assign st.out_free = !out_valid || !out_stall;
  assign st.n1_zero  = (n1 == '0);
  assign st.n1_ge    = (n1 >= count);
  assign st.lvl_last = (lvl == IDX_LAST);
  assign st.mul_done = mdone;
  assign st.lhs_gt   = (lhs > rhs);

endmodule
`default_nettype wire

/* sv/otb_ctrl.sv */
// sequencer for accumulate, search and binarize
`default_nettype none
module otb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               cmd,
  input  wire logic               frame_end,
  input  wire otb_pkg::dp_status_t st,
  output otb_pkg::ctrl_cmd_t      ctl
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ACC   = 4'd1;
  localparam logic [3:0] ST_SINIT = 4'd2;
  localparam logic [3:0] ST_SRD   = 4'd3;
  localparam logic [3:0] ST_SADD  = 4'd4;
  localparam logic [3:0] ST_SCHK  = 4'd5;
  localparam logic [3:0] ST_MGO   = 4'd6;
  localparam logic [3:0] ST_MWAIT = 4'd7;
  localparam logic [3:0] ST_SCMP  = 4'd8;
  localparam logic [3:0] ST_SNEXT = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  logic [3:0]    state;
  logic [3:0]    state_next;
  otb_pkg::mop_t mop;
  otb_pkg::mop_t mop_next;
  logic          fend_q;
  logic          accept;

  assign accept   = (state == ST_IDLE) && in_valid && st.out_free;
  assign in_stall = !((state == ST_IDLE) && st.out_free);

  always_comb begin
    state_next    = state;
    mop_next      = mop;
    ctl           = '0;
    ctl.mop       = mop;
    ctl.accept    = accept;
    unique case (state)
      ST_IDLE: begin
        if (accept && (cmd == otb_pkg::CMD_ACC)) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        ctl.acc_wr = 1'b1;
        state_next = fend_q ? ST_SINIT : ST_IDLE;
      end
      ST_SINIT: begin
        ctl.srch_init = 1'b1;
        state_next    = ST_SRD;
      end
      ST_SRD: begin
        ctl.lvl_rd = 1'b1;
        state_next = ST_SADD;
      end
      ST_SADD: begin
        ctl.bin_add = 1'b1;
        state_next  = ST_SCHK;
      end
      ST_SCHK: begin
        priority if (st.n1_ge) begin
          state_next = ST_FIN;
        end else if (st.n1_zero) begin
          state_next = ST_SNEXT;
        end else begin
          mop_next   = otb_pkg::MOP_X;
          state_next = ST_MGO;
        end
      end
      ST_MGO: begin
        ctl.mul_start = 1'b1;
        state_next    = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (st.mul_done) begin
          ctl.mul_take = 1'b1;
          state_next   = ST_MGO;
          unique case (mop)
            otb_pkg::MOP_X: mop_next = otb_pkg::MOP_Y;
            otb_pkg::MOP_Y: mop_next = otb_pkg::MOP_D;
            otb_pkg::MOP_D: mop_next = otb_pkg::MOP_P;
            otb_pkg::MOP_P: mop_next = otb_pkg::MOP_L;
            otb_pkg::MOP_L: mop_next = otb_pkg::MOP_R;
            default:        state_next = ST_SCMP;
          endcase
        end
      end
      ST_SCMP: begin
        ctl.best_upd = st.lhs_gt;
        state_next   = ST_SNEXT;
      end
      ST_SNEXT: begin
        if (st.lvl_last) begin
          state_next = ST_FIN;
        end else begin
          ctl.lvl_inc = 1'b1;
          state_next  = ST_SRD;
        end
      end
      ST_FIN: begin
        if (st.out_free) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mop   <= otb_pkg::MOP_X;
    end else begin
      state <= state_next;
      mop   <= mop_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fend_q <= frame_end;
    end
  end

endmodule
`default_nettype wire

/* sv/otsu_threshold_binarizer.sv */
// top level of the otsu threshold binarizer
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   cmd, pixel, frame_end
//  out      output     out_valid / out_stall result_kind, value
//
// a binarize item's result is registered for the next cycle
// an accumulate item reads the histogram when accepted, then writes back
// per level the search reads, adds and checks, then steps on while the lower class
// is empty, else it runs the six shift-add multiplies, then compares and steps on
// reset is synchronous and clears the histogram valid bits at once
// the input stalls outside idle, and while a result waits behind out_stall and the slot is full
`default_nettype none
module otsu_threshold_binarizer #(
  parameter int MAX_PIXELS  = 1048576,
  parameter int GRAY_LEVELS = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       cmd,
  input  wire logic [7:0] pixel,
  input  wire logic       frame_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            result_kind,
  output logic [7:0]      value
);

  otb_pkg::ctrl_cmd_t  ctl;
  otb_pkg::dp_status_t st;

  otb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .frame_end (frame_end),
    .st        (st),
    .ctl       (ctl)
  );

  otb_datapath #(
    .MAX_PIXELS  (MAX_PIXELS),
    .GRAY_LEVELS (GRAY_LEVELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .st          (st),
    .cmd         (cmd),
    .pixel       (pixel),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .value       (value)
  );

endmodule
`default_nettype wire

/* sv/otb_checker.sv */
// port-level checks for the otsu threshold binarizer
`default_nettype none
`include "assert_macros.svh"
module otb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       cmd,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       result_kind,
  input wire logic [7:0] value
);

  logic in_bin;
  logic in_acc;
  logic pix_out;
  logic pix_ok;

  assign in_bin  = in_valid && !in_stall && (cmd == otb_pkg::CMD_BIN);
  assign in_acc  = in_valid && !in_stall && (cmd == otb_pkg::CMD_ACC);
  assign pix_out = out_valid && (result_kind == otb_pkg::KIND_PIXEL);
  assign pix_ok  = (value == otb_pkg::PIX_WHITE) || (value == otb_pkg::PIX_BLACK);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_IMPL(a_bin_value, clk, rst, pix_out, pix_ok)
  `ASSERT_NEXT(a_bin_result, clk, rst, in_bin, pix_out)
  `ASSERT_NEXT(a_acc_busy, clk, rst, in_acc, in_stall)

endmodule

bind otsu_threshold_binarizer otb_checker u_chk (.*);
`default_nettype wire
